// ===== rtl/sph_pkg.sv =====
// shared types and constants of the subsampled pixel histogram
`timescale 1ns / 1ps
package sph_pkg;

	localparam int POS_W   = 13;
	localparam int RAW_W   = 16;
	localparam int RANGE_W = 10;
	localparam int PB_W    = 5;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 3;
	localparam int CNT_BW  = 16;
	localparam int PCT_W   = 7;
	localparam int STAT_W  = 2;

	localparam int DROP_BITS = 10;
	localparam int PCT_SCALE = 100;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PIXEL = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_DISABLED = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;

	localparam logic [IDX_W-1:0] REG_ENABLED     = 3'd0;
	localparam logic [IDX_W-1:0] REG_AREA_LEFT   = 3'd1;
	localparam logic [IDX_W-1:0] REG_AREA_RIGHT  = 3'd2;
	localparam logic [IDX_W-1:0] REG_AREA_TOP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_AREA_BOTTOM = 3'd4;
	localparam logic [IDX_W-1:0] REG_PIXEL_BITS  = 3'd5;

	localparam logic [POS_W-1:0] POS_MAX       = 13'd8191;
	localparam logic [PB_W-1:0]  PIXEL_BITS_RST = 5'd12;

	typedef enum logic [1:0] {
		KIND_CLEAR,
		KIND_PIXEL,
		KIND_QUERY
	} kind_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_RUN,
		ST_CLEAR,
		ST_SCAN,
		ST_TAIL,
		ST_MUL,
		ST_DIV
	} back_state_t;

	typedef struct packed {
		logic             enabled;
		logic [POS_W-1:0] area_left;
		logic [POS_W-1:0] area_right;
		logic [POS_W-1:0] area_top;
		logic [POS_W-1:0] area_bottom;
		logic [PB_W-1:0]  pixel_bits;
	} cfg_t;

endpackage

// ===== rtl/sph_front.sv =====
// front end: filters, bins and grid-checks incoming beats
`timescale 1ns / 1ps
module sph_front import sph_pkg::*; #(
	parameter int BIN_COUNT = 1024,
	parameter int GRID_STEP = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       accept,
	input  logic [1:0]                 op,
	input  logic [POS_W-1:0]           col,
	input  logic [POS_W-1:0]           row,
	input  logic [RAW_W-1:0]           raw_value,
	input  logic [RANGE_W-1:0]         range_from,
	input  logic [RANGE_W-1:0]         range_to,
	output logic                       push,
	output kind_t                      push_kind,
	output logic [$clog2(BIN_COUNT)-1:0] push_bin,
	output logic [RANGE_W-1:0]         push_from,
	output logic [RANGE_W-1:0]         push_to,
	output logic [1:0]                 inflight
);

	localparam int BIN_W  = $clog2(BIN_COUNT);
	localparam int REC_S  = 21;
	localparam int REC_W  = REC_S + 1;
	localparam int RECIP  = (2 ** REC_S + GRID_STEP - 1) / GRID_STEP;
	localparam int PROD_W = REC_W + POS_W;
	localparam int G_W    = 8;
	localparam int CHK_W  = POS_W + G_W;

	logic               valid_s1, valid_s2, valid_s3;
	kind_t              kind_s1, kind_s2, kind_s3;
	logic [POS_W-1:0]   col_s1, row_s1;
	logic [RAW_W-1:0]   raw_s1;
	logic [RANGE_W-1:0] from_s1, to_s1, from_s2, to_s2, from_s3, to_s3;
	logic [POS_W-1:0]   dc_s2, dr_s2, dc_s3, dr_s3, qc_s3, qr_s3;
	logic               cin_s2, rin_s2, cin_s3, rin_s3;
	logic [BIN_W-1:0]   bin_s2, bin_s3;

	logic               keep_op;
	kind_t              kind_in;
	logic [PB_W-1:0]    shift;
	logic [RAW_W-1:0]   shifted;
	logic [BIN_W-1:0]   bin_calc;
	logic [PROD_W-1:0]  pc, pr;
	logic [CHK_W-1:0]   chk_c, chk_r;
	logic               on_grid;

	always_comb begin
		keep_op = 1'b0;
		kind_in = KIND_PIXEL;
		unique case (op)
			OP_CLEAR: begin
				keep_op = cfg.enabled;
				kind_in = KIND_CLEAR;
			end
			OP_PIXEL: begin
				keep_op = cfg.enabled;
				kind_in = KIND_PIXEL;
			end
			OP_QUERY: begin
				keep_op = 1'b1;
				kind_in = KIND_QUERY;
			end
			default: begin
				keep_op = 1'b0;
				kind_in = KIND_PIXEL;
			end
		endcase
	end

	always_comb begin
		shift = (cfg.pixel_bits > PB_W'(DROP_BITS)) ? cfg.pixel_bits - PB_W'(DROP_BITS) : '0;
		shifted = raw_s1 >> shift;
		if (shifted > RAW_W'(BIN_COUNT - 1)) begin
			bin_calc = BIN_W'(BIN_COUNT - 1);
		end else begin
			bin_calc = shifted[BIN_W-1:0];
		end
	end

	assign pc = PROD_W'(dc_s2) * PROD_W'(RECIP);
	assign pr = PROD_W'(dr_s2) * PROD_W'(RECIP);

	assign chk_c = CHK_W'(qc_s3) * CHK_W'(GRID_STEP);
	assign chk_r = CHK_W'(qr_s3) * CHK_W'(GRID_STEP);
	assign on_grid = cin_s3 && rin_s3 && (chk_c == CHK_W'(dc_s3)) && (chk_r == CHK_W'(dr_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= accept && keep_op;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind_in;
		col_s1  <= col;
		row_s1  <= row;
		raw_s1  <= raw_value;
		from_s1 <= range_from;
		to_s1   <= range_to;

		kind_s2 <= kind_s1;
		dc_s2   <= col_s1 - cfg.area_left;
		dr_s2   <= row_s1 - cfg.area_top;
		cin_s2  <= (col_s1 >= cfg.area_left) && (col_s1 < cfg.area_right);
		rin_s2  <= (row_s1 >= cfg.area_top) && (row_s1 < cfg.area_bottom);
		bin_s2  <= bin_calc;
		from_s2 <= from_s1;
		to_s2   <= to_s1;

		kind_s3 <= kind_s2;
		dc_s3   <= dc_s2;
		dr_s3   <= dr_s2;
		qc_s3   <= pc[REC_S+POS_W-1:REC_S];
		qr_s3   <= pr[REC_S+POS_W-1:REC_S];
		cin_s3  <= cin_s2;
		rin_s3  <= rin_s2;
		bin_s3  <= bin_s2;
		from_s3 <= from_s2;
		to_s3   <= to_s2;
	end

	assign push      = valid_s3 && ((kind_s3 != KIND_PIXEL) || on_grid);
	assign push_kind = kind_s3;
	assign push_bin  = bin_s3;
	assign push_from = from_s3;
	assign push_to   = to_s3;
	assign inflight  = 2'({1'b0, valid_s1} + {1'b0, valid_s2} + {1'b0, valid_s3});

endmodule

// ===== rtl/sph_queue.sv =====
// small fifo between front and back end
`timescale 1ns / 1ps
module sph_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic                         head_valid,
	output logic [WIDTH-1:0]             head_data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = count_q != '0;
	assign head_data  = slots_q[rd_ptr_q];
	assign count      = count_q;

endmodule

// ===== rtl/sph_back.sv =====
// back end: bin memory, increments, clear and query sweeps, percentage divide
`timescale 1ns / 1ps
module sph_back import sph_pkg::*; #(
	parameter int BIN_COUNT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         head_valid,
	input  kind_t                        head_kind,
	input  logic [$clog2(BIN_COUNT)-1:0] head_bin,
	input  logic [RANGE_W-1:0]           head_from,
	input  logic [RANGE_W-1:0]           head_to,
	output logic                         pop,
	output logic                         init_busy,
	output logic                         result_valid,
	output logic [PCT_W-1:0]             percent,
	output logic [STAT_W-1:0]            status
);

	localparam int BIN_W = $clog2(BIN_COUNT);
	localparam int SUM_W = CNT_BW + BIN_W;
	localparam int NUM_W = SUM_W + PCT_W;
	localparam int CMP_W = (BIN_W > RANGE_W) ? BIN_W : RANGE_W;

	logic [CNT_BW-1:0] bins_mem [BIN_COUNT];

	back_state_t       state_q, state_d;
	logic [BIN_W-1:0]  cnt_q;
	logic              cnt_last;

	logic              upd_valid_s1;
	logic [BIN_W-1:0]  upd_addr_s1;
	logic [CNT_BW-1:0] rdata_q;
	logic              fwd_valid_q;
	logic [BIN_W-1:0]  fwd_addr_q;
	logic [CNT_BW-1:0] fwd_data_q;
	logic [CNT_BW-1:0] upd_sum;

	logic              scan_valid_s1;
	logic [BIN_W-1:0]  scan_idx_s1;
	logic [RANGE_W-1:0] from_q, to_q;
	logic [SUM_W-1:0]  total_q, inside_q;
	logic              in_range;

	logic [NUM_W-1:0]  num_q, div_q;
	logic [PCT_W-2:0]  quo_q;
	logic [2:0]        step_q;
	logic              ge;

	logic              result_valid_q;
	logic [PCT_W-1:0]  percent_q;
	logic [STAT_W-1:0] status_q;

	logic              mem_we, mem_re;
	logic [BIN_W-1:0]  mem_wa, mem_ra;
	logic [CNT_BW-1:0] mem_wd;
	logic              emit;
	logic [STAT_W-1:0] emit_status;
	logic [PCT_W-1:0]  emit_percent;
	logic              start_query, start_clear, take_pixel;

	assign cnt_last = cnt_q == BIN_W'(BIN_COUNT - 1);
	assign upd_sum  = ((fwd_valid_q && (fwd_addr_q == upd_addr_s1)) ? fwd_data_q : rdata_q)
		+ 1'b1;
	assign in_range = (CMP_W'(scan_idx_s1) >= CMP_W'(from_q))
		&& (CMP_W'(scan_idx_s1) <= CMP_W'(to_q));
	assign ge = num_q >= div_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (cnt_last) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (start_clear) begin
					state_d = ST_CLEAR;
				end else if (start_query && cfg.enabled) begin
					state_d = ST_SCAN;
				end
			end
			ST_CLEAR: begin
				if (cnt_last) state_d = ST_RUN;
			end
			ST_SCAN: begin
				if (cnt_last) state_d = ST_TAIL;
			end
			ST_TAIL: state_d = ST_MUL;
			ST_MUL: begin
				state_d = (total_q == '0) ? ST_RUN : ST_DIV;
			end
			ST_DIV: begin
				if (step_q == '0) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop          = 1'b0;
		take_pixel   = 1'b0;
		start_clear  = 1'b0;
		start_query  = 1'b0;
		mem_re       = 1'b0;
		mem_ra       = head_bin;
		mem_we       = 1'b0;
		mem_wa       = upd_addr_s1;
		mem_wd       = upd_sum;
		emit         = 1'b0;
		emit_status  = STATUS_OK;
		emit_percent = '0;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = cnt_q;
				mem_wd = '0;
			end
			ST_RUN: begin
				mem_we = upd_valid_s1;
				if (head_valid) begin
					unique case (head_kind)
						KIND_PIXEL: begin
							pop        = 1'b1;
							take_pixel = 1'b1;
							mem_re     = 1'b1;
						end
						KIND_CLEAR: begin
							pop         = !upd_valid_s1;
							start_clear = !upd_valid_s1;
						end
						KIND_QUERY: begin
							pop         = !upd_valid_s1;
							start_query = !upd_valid_s1;
							if (!upd_valid_s1 && !cfg.enabled) begin
								emit        = 1'b1;
								emit_status = STATUS_DISABLED;
							end
						end
						default: pop = 1'b1;
					endcase
				end
			end
			ST_SCAN: begin
				mem_re = 1'b1;
				mem_ra = cnt_q;
			end
			ST_TAIL: ;
			ST_MUL: begin
				if (total_q == '0) begin
					emit        = 1'b1;
					emit_status = STATUS_EMPTY;
				end
			end
			ST_DIV: begin
				if (step_q == '0) begin
					emit         = 1'b1;
					emit_percent = {quo_q, ge};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= bins_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			cnt_q          <= '0;
			upd_valid_s1   <= 1'b0;
			fwd_valid_q    <= 1'b0;
			scan_valid_s1  <= 1'b0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			upd_valid_s1   <= take_pixel;
			fwd_valid_q    <= upd_valid_s1;
			scan_valid_s1  <= state_q == ST_SCAN;
			if (state_q == ST_MUL) begin
				step_q <= 3'(PCT_W - 1);
			end else if (state_q == ST_DIV) begin
				step_q <= step_q - 1'b1;
			end
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		upd_addr_s1 <= head_bin;
		fwd_addr_q  <= upd_addr_s1;
		fwd_data_q  <= upd_sum;
		scan_idx_s1 <= cnt_q;
		if (start_query) begin
			from_q   <= head_from;
			to_q     <= head_to;
			total_q  <= '0;
			inside_q <= '0;
		end else if (scan_valid_s1) begin
			total_q <= total_q + SUM_W'(rdata_q);
			if (in_range) begin
				inside_q <= inside_q + SUM_W'(rdata_q);
			end
		end
		if (state_q == ST_MUL) begin
			num_q <= NUM_W'(inside_q) * NUM_W'(PCT_SCALE) + NUM_W'(total_q >> 1);
			div_q <= NUM_W'(total_q) << (PCT_W - 1);
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (ge) begin
				num_q <= num_q - div_q;
			end
			div_q <= div_q >> 1;
			quo_q <= {quo_q[PCT_W-3:0], ge};
		end
		if (emit) begin
			percent_q <= emit_percent;
			status_q  <= emit_status;
		end
	end

	assign init_busy    = state_q == ST_INIT;
	assign result_valid = result_valid_q;
	assign percent      = percent_q;
	assign status       = status_q;

endmodule

// ===== rtl/subsampled_pixel_histogram_unit.sv =====
// top level of the subsampled pixel histogram
`timescale 1ns / 1ps
// Brightness histogram over a subsampled grid of raw sensor pixels.
// Command channel: a beat (op, col, row, raw_value, range_from, range_to) is
// taken on a rising edge with start high and busy low. op selects clear, pixel
// sample or range query; any other op is dropped.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write registers only while the block is idle.
// Result channel: one result_valid strobe per query carrying percent and
// status; the receiver cannot stall, so each result is shown for one cycle.
// Pixel samples stream at one per cycle while busy is low: three front stages
// grid-check and bin them, an eight-entry queue feeds the back end, which does a
// read-modify-write of the bin memory per cycle outside clear and query sweeps,
// with write forwarding. busy rises when the queue and front stages could fill.
// A clear sweeps every bin of the memory; a query reads every bin, then does a
// multiply and, unless the total is zero, a seven-step divide. A query with
// collection disabled answers without a sweep.
// After reset the bin memory is cleared with busy high.
module subsampled_pixel_histogram_unit import sph_pkg::*; #(
	parameter int BIN_COUNT = 1024,
	parameter int GRID_STEP = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [POS_W-1:0]   col,
	input  logic [POS_W-1:0]   row,
	input  logic [RAW_W-1:0]   raw_value,
	input  logic [RANGE_W-1:0] range_from,
	input  logic [RANGE_W-1:0] range_to,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [PCT_W-1:0]   percent,
	output logic [STAT_W-1:0]  status
);

	localparam int BIN_W   = $clog2(BIN_COUNT);
	localparam int Q_DEPTH = 8;
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
	localparam int ENTRY_W = 2 + BIN_W + 2 * RANGE_W;

	cfg_t                cfg_q;
	logic                accept;
	logic                push, pop, head_valid, init_busy;
	kind_t               push_kind, head_kind;
	logic [BIN_W-1:0]    push_bin, head_bin;
	logic [RANGE_W-1:0]  push_from, push_to, head_from, head_to;
	logic [1:0]          inflight;
	logic [ENTRY_W-1:0]  push_data, head_data;
	logic [Q_CNT_W-1:0]  q_count;
	logic [Q_CNT_W:0]    fill;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled     <= 1'b1;
			cfg_q.area_left   <= '0;
			cfg_q.area_right  <= POS_MAX;
			cfg_q.area_top    <= '0;
			cfg_q.area_bottom <= POS_MAX;
			cfg_q.pixel_bits  <= PIXEL_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLED:     cfg_q.enabled     <= cfg_data[0];
				REG_AREA_LEFT:   cfg_q.area_left   <= cfg_data;
				REG_AREA_RIGHT:  cfg_q.area_right  <= cfg_data;
				REG_AREA_TOP:    cfg_q.area_top    <= cfg_data;
				REG_AREA_BOTTOM: cfg_q.area_bottom <= cfg_data;
				REG_PIXEL_BITS:  cfg_q.pixel_bits  <= cfg_data[PB_W-1:0];
				default: ;
			endcase
		end
	end

	assign fill   = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(inflight);
	assign busy   = init_busy || (fill >= (Q_CNT_W + 1)'(Q_DEPTH));
	assign accept = start && !busy;

	sph_front #(
		.BIN_COUNT(BIN_COUNT),
		.GRID_STEP(GRID_STEP)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.op         (op),
		.col        (col),
		.row        (row),
		.raw_value  (raw_value),
		.range_from (range_from),
		.range_to   (range_to),
		.push       (push),
		.push_kind  (push_kind),
		.push_bin   (push_bin),
		.push_from  (push_from),
		.push_to    (push_to),
		.inflight   (inflight)
	);

	assign push_data = {push_kind, push_bin, push_from, push_to};

	sph_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (q_count)
	);

	assign head_kind = kind_t'(head_data[ENTRY_W-1 -: 2]);
	assign head_bin  = head_data[2*RANGE_W +: BIN_W];
	assign head_from = head_data[RANGE_W +: RANGE_W];
	assign head_to   = head_data[0 +: RANGE_W];

	sph_back #(
		.BIN_COUNT(BIN_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head_valid   (head_valid),
		.head_kind    (head_kind),
		.head_bin     (head_bin),
		.head_from    (head_from),
		.head_to      (head_to),
		.pop          (pop),
		.init_busy    (init_busy),
		.result_valid (result_valid),
		.percent      (percent),
		.status       (status)
	);

endmodule

// ===== rtl/sph_checker.sv =====
// port-level checks of the histogram unit and their binding
`timescale 1ns / 1ps
module sph_checker import sph_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic               result_valid,
	input logic [PCT_W-1:0]   percent,
	input logic [STAT_W-1:0]  status
);

	// flagged results carry no percentage
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != STATUS_OK) |-> percent == '0)
		else $error("flagged result with nonzero percent");

	// valid results stay within a hundred percent and use a known status
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (percent <= PCT_W'(PCT_SCALE))
			&& (status == STATUS_OK || status == STATUS_DISABLED || status == STATUS_EMPTY))
		else $error("result out of range");

	// flow control is always driven to a known level
	a_busy_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(busy))
		else $error("busy unknown");

	// config channel never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config beat stalled");

endmodule

bind subsampled_pixel_histogram_unit sph_checker u_sph_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench of the subsampled pixel histogram unit, checked against a bin-level model
module testbench;
	import sph_pkg::*;

	localparam int BINS   = 1024;
	localparam int GRID   = 31;
	localparam int SETTLE = 12 * (BINS + 16);
	localparam int LIMIT  = 4000000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [PCT_W-1:0]  pct;
		logic [STAT_W-1:0] stat;
	} answer_t;

	class histogram_tracker;
		logic [CNT_BW-1:0] tally [BINS];
		cfg_t regs;
		answer_t answers_due [$];
		int mismatches = 0;
		int answered = 0;

		function void power_up();
			foreach (tally[i]) tally[i] = '0;
			regs.enabled     = 1'b1;
			regs.area_left   = '0;
			regs.area_right  = POS_MAX;
			regs.area_top    = '0;
			regs.area_bottom = POS_MAX;
			regs.pixel_bits  = PIXEL_BITS_RST;
		endfunction

		function void write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			case (idx)
			REG_ENABLED:     regs.enabled     = data[0];
			REG_AREA_LEFT:   regs.area_left   = data[POS_W-1:0];
			REG_AREA_RIGHT:  regs.area_right  = data[POS_W-1:0];
			REG_AREA_TOP:    regs.area_top    = data[POS_W-1:0];
			REG_AREA_BOTTOM: regs.area_bottom = data[POS_W-1:0];
			REG_PIXEL_BITS:  regs.pixel_bits  = data[PB_W-1:0];
			default: ;
			endcase
		endfunction

		function bit on_grid(input int unsigned pos, first, past);
			if (pos < first || pos >= past)
				return 1'b0;
			return ((pos - first) % GRID) == 0;
		endfunction

		function void take_command(input logic [1:0] code, input logic [POS_W-1:0] c, r,
				input logic [RAW_W-1:0] raw, input logic [RANGE_W-1:0] lo, hi);
			int unsigned shift;
			int unsigned slot;
			longint unsigned total;
			longint unsigned in_range;
			answer_t ans;
			case (code)
			OP_CLEAR: begin
				if (regs.enabled)
					foreach (tally[i]) tally[i] = '0;
			end
			OP_PIXEL: begin
				if (regs.enabled && on_grid(c, regs.area_left, regs.area_right)
						&& on_grid(r, regs.area_top, regs.area_bottom)) begin
					shift = (regs.pixel_bits > DROP_BITS) ? regs.pixel_bits - DROP_BITS : 0;
					slot = raw >> shift;
					if (slot > BINS - 1)
						slot = BINS - 1;
					tally[slot] = tally[slot] + 1'b1;
				end
			end
			OP_QUERY: begin
				ans.pct = '0;
				total = 0;
				in_range = 0;
				if (!regs.enabled) begin
					ans.stat = STATUS_DISABLED;
				end else begin
					foreach (tally[i]) begin
						total += tally[i];
						if (i >= lo && i <= hi)
							in_range += tally[i];
					end
					if (total == 0) begin
						ans.stat = STATUS_EMPTY;
					end else begin
						ans.stat = STATUS_OK;
						ans.pct = PCT_W'((in_range * PCT_SCALE + total / 2) / total);
					end
				end
				answers_due.push_back(ans);
			end
			default: ;
			endcase
		endfunction

		function void match_answer(input logic [PCT_W-1:0] pct, input logic [STAT_W-1:0] stat);
			answer_t want;
			if (answers_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with none pending, percent %0d status %0d", $time, pct, stat);
				return;
			end
			want = answers_due.pop_front();
			answered++;
			if (pct !== want.pct) begin
				mismatches++;
				$display("%0t: percent expected %0d, got %0d", $time, want.pct, pct);
			end
			if (stat !== want.stat) begin
				mismatches++;
				$display("%0t: status expected %0d, got %0d", $time, want.stat, stat);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic [POS_W-1:0]   col;
	logic [POS_W-1:0]   row;
	logic [RAW_W-1:0]   raw_value;
	logic [RANGE_W-1:0] range_from;
	logic [RANGE_W-1:0] range_to;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               result_valid;
	logic [PCT_W-1:0]   percent;
	logic [STAT_W-1:0]  status;

	histogram_tracker sb;
	int cycles = 0;
	int beats = 0;
	int settings = 0;

	subsampled_pixel_histogram_unit #(.BIN_COUNT(BINS), .GRID_STEP(GRID)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.match_answer(percent, status);
	end

	task automatic issue(input logic [1:0] code, input logic [POS_W-1:0] c, r,
			input logic [RAW_W-1:0] raw, input logic [RANGE_W-1:0] lo, hi);
		op         <= code;
		col        <= c;
		row        <= r;
		raw_value  <= raw;
		range_from <= lo;
		range_to   <= hi;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		sb.take_command(code, c, r, raw, lo, hi);
		beats++;
	endtask

	task automatic pause(input bit quiet);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if (quiet || r < 45)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// idle point: all answers in, clear or pixel work finished
	task automatic drain();
		start <= 1'b0;
		while (sb.answers_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		logic [IDX_W-1:0] idx [6] = '{REG_ENABLED, REG_AREA_LEFT, REG_AREA_RIGHT,
			REG_AREA_TOP, REG_AREA_BOTTOM, REG_PIXEL_BITS};
		logic [CFG_W-1:0] vals [6];
		vals[0] = CFG_W'(c.enabled);
		vals[1] = CFG_W'(c.area_left);
		vals[2] = CFG_W'(c.area_right);
		vals[3] = CFG_W'(c.area_top);
		vals[4] = CFG_W'(c.area_bottom);
		vals[5] = CFG_W'(c.pixel_bits);
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	function automatic cfg_t pick_config(input int phase);
		cfg_t c;
		c.enabled = (phase == 2) ? 1'b0 : ($urandom_range(0, 7) != 0);
		case ($urandom_range(0, 5))
		0: c.pixel_bits = 5'd0;
		1: c.pixel_bits = 5'd9;
		2: c.pixel_bits = 5'd10;
		3: c.pixel_bits = 5'd16;
		4: c.pixel_bits = 5'd31;
		default: c.pixel_bits = PB_W'($urandom_range(10, 16));
		endcase
		c.area_left   = '0;
		c.area_right  = POS_MAX;
		c.area_top    = '0;
		c.area_bottom = POS_MAX;
		case ($urandom_range(0, 4))
		0: ;
		1: begin
			c.area_left   = POS_W'($urandom_range(0, 7600));
			c.area_right  = c.area_left + POS_W'($urandom_range(1, 500));
			c.area_top    = POS_W'($urandom_range(0, 7600));
			c.area_bottom = c.area_top + POS_W'($urandom_range(1, 500));
		end
		2: begin
			c.area_left  = POS_W'($urandom);
			c.area_right = POS_W'($urandom_range(0, c.area_left));
		end
		3: begin
			c.area_left   = POS_W'($urandom);
			c.area_right  = POS_W'($urandom);
			c.area_top    = POS_W'($urandom);
			c.area_bottom = POS_W'($urandom);
		end
		default: begin
			c.area_left   = POS_MAX - POS_W'($urandom_range(0, 100));
			c.area_bottom = POS_W'($urandom_range(1, 40));
		end
		endcase
		if (phase == 0 || phase == 7) begin
			c.enabled     = 1'b1;
			c.area_left   = '0;
			c.area_right  = POS_MAX;
			c.area_top    = '0;
			c.area_bottom = POS_MAX;
			c.pixel_bits  = (phase == 0) ? 5'd16 : 5'd10;
		end
		return c;
	endfunction

	function automatic logic [POS_W-1:0] grid_pos(input logic [POS_W-1:0] first, past);
		int unsigned steps;
		if (past <= first)
			return POS_W'($urandom);
		steps = (past - first - 1) / GRID;
		return POS_W'(first + GRID * $urandom_range(0, steps));
	endfunction

	task automatic run_phase(input cfg_t c, input int count);
		int unsigned pick;
		bit quiet;
		logic [1:0] code;
		logic [POS_W-1:0] x, y;
		logic [RAW_W-1:0] raw;
		logic [RANGE_W-1:0] lo, hi, t;
		quiet = ($urandom_range(0, 3) == 0);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			x = POS_W'($urandom);
			y = POS_W'($urandom);
			raw = RAW_W'($urandom) >> $urandom_range(0, 12);
			lo = RANGE_W'($urandom);
			hi = RANGE_W'($urandom);
			if (pick < 3) begin
				code = OP_CLEAR;
			end else if (pick < 18) begin
				code = OP_QUERY;
				if (lo > hi && $urandom_range(0, 2) != 0) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end else if (pick < 21) begin
				code = OP_UNUSED;
			end else begin
				code = OP_PIXEL;
				if (pick < 88) begin
					x = grid_pos(c.area_left, c.area_right);
					y = grid_pos(c.area_top, c.area_bottom);
				end
			end
			issue(code, x, y, raw, lo, hi);
			pause(quiet);
		end
	endtask

	initial begin
		cfg_t c;
		sb = new;
		sb.power_up();
		arst_n     <= 1'b0;
		start      <= 1'b0;
		op         <= OP_CLEAR;
		col        <= '0;
		row        <= '0;
		raw_value  <= '0;
		range_from <= '0;
		range_to   <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= REG_ENABLED;
		cfg_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// reset settings: full area, twelve-bit pixels
		issue(OP_QUERY, 0, 0, 0, 0, 1023);
		issue(OP_PIXEL, 0, 0, 16'h0000, 0, 0);
		issue(OP_PIXEL, 31, 62, 16'hFFFF, 0, 0);
		issue(OP_PIXEL, 8184, 8184, 16'd4092, 0, 0);
		issue(OP_PIXEL, 1, 0, 16'd7, 0, 0);
		issue(OP_PIXEL, POS_MAX, POS_MAX, 16'd7, 0, 0);
		issue(OP_UNUSED, 0, 0, 0, 0, 1023);
		issue(OP_QUERY, 0, 0, 0, 0, 1023);
		issue(OP_QUERY, 0, 0, 0, 1023, 0);
		issue(OP_QUERY, 0, 0, 0, 0, 0);
		issue(OP_QUERY, 0, 0, 0, 1023, 1023);

		drain();
		c = sb.regs;
		c.enabled = 1'b0;
		load_config(c);
		issue(OP_CLEAR, 0, 0, 0, 0, 0);
		issue(OP_PIXEL, 0, 0, 16'd5, 0, 0);
		issue(OP_QUERY, 0, 0, 0, 0, 1023);

		// narrow pixels keep the raw value
		drain();
		c.enabled = 1'b1;
		c.pixel_bits = 5'd0;
		load_config(c);
		issue(OP_QUERY, 0, 0, 0, 0, 1023);
		issue(OP_PIXEL, 0, 0, 16'd1023, 0, 0);
		issue(OP_PIXEL, 0, 0, 16'd5, 0, 0);
		issue(OP_QUERY, 0, 0, 0, 5, 5);
		issue(OP_CLEAR, 0, 0, 0, 0, 0);
		issue(OP_QUERY, 0, 0, 0, 0, 1023);

		// empty column range
		drain();
		c.area_left = 13'd100;
		c.area_right = 13'd100;
		c.pixel_bits = 5'd31;
		load_config(c);
		issue(OP_PIXEL, 100, 0, 16'hFFFF, 0, 0);
		issue(OP_QUERY, 0, 0, 0, 0, 1023);

		for (int p = 0; p < 8; p++) begin
			drain();
			c = pick_config(p);
			load_config(c);
			run_phase(c, 103);
		end
		drain();

		$display("covered %0d command beats over %0d register settings", beats, settings);
		$display("%0d query answers compared, %0d mismatches", sb.answered, sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
